[rtl/core/bcd_pkg.sv]
// Shared types and constants for the bounded circular deque.
`timescale 1ns / 1ps
package bcd_pkg;

  localparam int unsigned Depth     = 16;
  localparam int unsigned IdxW      = $clog2(Depth);
  localparam int unsigned CntW      = $clog2(Depth + 1);
  localparam int unsigned DataW     = 32;
  localparam int unsigned OpW       = 3;
  localparam int unsigned CapResetV = 16;

  typedef enum logic [OpW-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_DEL_FRONT = 3'd2,
    OP_DEL_BACK  = 3'd3,
    OP_NONE      = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_LOAD = 3'b100
  } state_e;

  typedef struct packed {
    logic load;
    logic accepted;
    logic empty;
    logic full;
  } resp_t;

endpackage

[rtl/core/bcd_ram.sv]
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
module bcd_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

[rtl/core/bcd_ctrl.sv]
// Deque control: capacity, head/tail/count registers, slot writes and read sequencing.
`timescale 1ns / 1ps
module bcd_ctrl import bcd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [OpW-1:0]   op_i,
  input  logic             cfg_we_i,
  input  logic [CntW-1:0]  cfg_data_i,
  input  logic             out_free_i,
  output logic             ram_we_o,
  output logic [IdxW-1:0]  ram_waddr_o,
  output logic             ram_re_o,
  output logic [IdxW-1:0]  ram_raddr_a_o,
  output logic [IdxW-1:0]  ram_raddr_b_o,
  output resp_t            resp_o
);

  state_e          state_q, state_d;
  logic [CntW-1:0] cap_q;
  logic [IdxW-1:0] head_q, head_d;
  logic [IdxW-1:0] tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;
  logic            acc_q, acc_d;
  logic [CntW-1:0] cap_eff;
  logic            full, empty, fire;
  logic [IdxW-1:0] head_dec, head_inc, tail_dec, tail_inc, cap_last;

  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CntW'(1);
    end else if (cap_q > CntW'(Depth)) begin
      cap_eff = CntW'(Depth);
    end else begin
      cap_eff = cap_q;
    end
  end

  assign cap_last = IdxW'(cap_eff - CntW'(1));
  assign full     = count_q >= cap_eff;
  assign empty    = count_q == '0;
  assign fire     = in_valid_i && (state_q == S_IDLE);

  assign head_dec = (head_q == '0) ? cap_last : head_q - IdxW'(1);
  assign tail_dec = (tail_q == '0) ? cap_last : tail_q - IdxW'(1);
  assign head_inc = ((CntW'(head_q) + CntW'(1)) >= cap_eff) ? '0 : head_q + IdxW'(1);
  assign tail_inc = ((CntW'(tail_q) + CntW'(1)) >= cap_eff) ? '0 : tail_q + IdxW'(1);

  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    acc_d       = acc_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = '0;
    if (fire) begin
      acc_d = 1'b0;
      unique case (op_i) inside
        OP_INS_FRONT, OP_INS_BACK: begin
          if (!full) begin
            acc_d    = 1'b1;
            ram_we_o = 1'b1;
            count_d  = count_q + CntW'(1);
            if (empty) begin
              head_d      = '0;
              tail_d      = '0;
              ram_waddr_o = '0;
            end else if (op_i == OP_INS_FRONT) begin
              head_d      = head_dec;
              ram_waddr_o = head_dec;
            end else begin
              tail_d      = tail_inc;
              ram_waddr_o = tail_inc;
            end
          end
        end
        OP_DEL_FRONT: begin
          if (!empty) begin
            acc_d   = 1'b1;
            head_d  = head_inc;
            count_d = count_q - CntW'(1);
          end
        end
        OP_DEL_BACK: begin
          if (!empty) begin
            acc_d   = 1'b1;
            tail_d  = tail_dec;
            count_d = count_q - CntW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (fire) state_d = S_READ;
      S_READ:  state_d = S_LOAD;
      S_LOAD:  if (out_free_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cap_q   <= CntW'(CapResetV);
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      acc_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      if (cfg_we_i) begin
        cap_q   <= cfg_data_i;
        head_q  <= '0;
        tail_q  <= '0;
        count_q <= '0;
      end else begin
        head_q  <= head_d;
        tail_q  <= tail_d;
        count_q <= count_d;
      end
    end
  end

  assign in_ready_o    = state_q == S_IDLE;
  assign ram_re_o      = state_q == S_READ;
  assign ram_raddr_a_o = head_q;
  assign ram_raddr_b_o = tail_q;

  assign resp_o.load     = (state_q == S_LOAD) && out_free_i;
  assign resp_o.accepted = acc_q;
  assign resp_o.empty    = empty;
  assign resp_o.full     = full;

endmodule

[rtl/core/bounded_circular_deque_top.sv]
// Top level of the bounded circular deque: control, slot RAM and result register.
// An accepted input beat passes through READ and LOAD to the result register, and no
// new input beat is taken until then (slot write, head/tail read, result load);
//   the next input beat is taken while a result beat still waits.
// Reset: head, tail and count clear, capacity returns to 16; slot RAM is not cleared.
`timescale 1ns / 1ps
module bounded_circular_deque_top import bcd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [OpW-1:0]          op_i,
  input  logic signed [DataW-1:0] value_i,
  input  logic                    cfg_we_i,
  input  logic [CntW-1:0]         cfg_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    accepted_o,
  output logic signed [DataW-1:0] front_value_o,
  output logic signed [DataW-1:0] rear_value_o,
  output logic                    is_empty_o,
  output logic                    is_full_o
);

  logic             ram_we, ram_re;
  logic [IdxW-1:0]  ram_waddr, ram_raddr_a, ram_raddr_b;
  logic [DataW-1:0] rdata_a, rdata_b;
  resp_t            resp;
  logic             out_valid_q;
  logic             out_free;
  logic             acc_q, empty_q, full_q;
  logic [DataW-1:0] front_q, rear_q;

  assign out_free = !out_valid_q || out_ready_i;

  bcd_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .out_free_i    (out_free),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_re_o      (ram_re),
    .ram_raddr_a_o (ram_raddr_a),
    .ram_raddr_b_o (ram_raddr_b),
    .resp_o        (resp)
  );

  bcd_ram #(
    .Width (DataW),
    .Depth (Depth)
  ) u_slots (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (value_i),
    .re_i      (ram_re),
    .raddr_a_i (ram_raddr_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (resp.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (resp.load) begin
      acc_q   <= resp.accepted;
      empty_q <= resp.empty;
      full_q  <= resp.full;
      front_q <= resp.empty ? '1 : rdata_a;
      rear_q  <= resp.empty ? '1 : rdata_b;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign accepted_o    = acc_q;
  assign front_value_o = front_q;
  assign rear_value_o  = rear_q;
  assign is_empty_o    = empty_q;
  assign is_full_o     = full_q;

endmodule

[verif/bounded_circular_deque_top_tb.sv]
// Self-checking testbench for the bounded circular deque: directed table, then random traffic.
`timescale 1ns / 1ps
module bounded_circular_deque_top_tb import bcd_pkg::*; ();

  typedef struct packed {
    logic             accepted;
    logic [DataW-1:0] front;
    logic [DataW-1:0] rear;
    logic             empty;
    logic             full;
  } deque_view_t;

  typedef struct packed {
    logic             is_cfg;
    logic [OpW-1:0]   op;
    logic [DataW-1:0] value;
    logic [CntW-1:0]  cap;
    logic             has_want;
    deque_view_t      want;
  } plan_row_t;

  localparam logic [DataW-1:0] EmptyMark  = '1;
  localparam int unsigned      StallLimit = 2000;
  localparam int unsigned      NumPhases  = 8;
  localparam int unsigned      PhaseBeats = 180;
  localparam logic [CntW-1:0]  PhaseCaps [NumPhases] = '{
    5'd16, 5'd1, 5'd4, 5'd0, 5'd0, 5'd17, 5'd2, 5'd31
  };

  logic                    clk_i;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_ready_o;
  logic [OpW-1:0]          op_i        = OP_NONE;
  logic signed [DataW-1:0] value_i     = '0;
  logic                    cfg_we_i    = 1'b0;
  logic [CntW-1:0]         cfg_data_i  = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic                    accepted_o;
  logic signed [DataW-1:0] front_value_o;
  logic signed [DataW-1:0] rear_value_o;
  logic                    is_empty_o;
  logic                    is_full_o;

  bounded_circular_deque_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .value_i       (value_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .accepted_o    (accepted_o),
    .front_value_o (front_value_o),
    .rear_value_o  (rear_value_o),
    .is_empty_o    (is_empty_o),
    .is_full_o     (is_full_o)
  );

  // predictor state
  logic [DataW-1:0] ring_slots [Depth];
  int unsigned      ring_head;
  int unsigned      ring_tail;
  int unsigned      ring_count;
  logic [CntW-1:0]  ring_cap;

  deque_view_t pending_views[$];
  int unsigned fail_count = 0;
  int unsigned beats_sent = 0;
  int unsigned burst_left = 0;
  bit          offering   = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic deque_view_t predict_step(logic [OpW-1:0] op, logic [DataW-1:0] val);
    deque_view_t v;
    int unsigned lim;
    lim = (ring_cap == 0) ? 1 : ((ring_cap > Depth) ? Depth : ring_cap);
    v.accepted = 1'b0;
    if (op == OP_INS_FRONT || op == OP_INS_BACK) begin
      if (ring_count < lim) begin
        if (ring_count == 0) begin
          ring_head = 0;
          ring_tail = 0;
          ring_slots[0] = val;
        end else if (op == OP_INS_FRONT) begin
          ring_head = (ring_head == 0) ? lim - 1 : ring_head - 1;
          ring_slots[ring_head] = val;
        end else begin
          ring_tail = (ring_tail + 1 >= lim) ? 0 : ring_tail + 1;
          ring_slots[ring_tail] = val;
        end
        ring_count++;
        v.accepted = 1'b1;
      end
    end else if (op == OP_DEL_FRONT || op == OP_DEL_BACK) begin
      if (ring_count != 0) begin
        if (op == OP_DEL_FRONT) ring_head = (ring_head + 1 >= lim) ? 0 : ring_head + 1;
        else ring_tail = (ring_tail == 0) ? lim - 1 : ring_tail - 1;
        ring_count--;
        v.accepted = 1'b1;
      end
    end
    v.empty = (ring_count == 0);
    v.full  = (ring_count >= lim);
    v.front = v.empty ? EmptyMark : ring_slots[ring_head];
    v.rear  = v.empty ? EmptyMark : ring_slots[ring_tail];
    return v;
  endfunction

  function automatic plan_row_t op_row(logic [OpW-1:0] op, logic [DataW-1:0] val);
    plan_row_t r;
    r = '0;
    r.op = op;
    r.value = val;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(logic [CntW-1:0] cap);
    plan_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.op = OP_NONE;
    r.cap = cap;
    return r;
  endfunction

  function automatic plan_row_t want_row(logic [OpW-1:0] op, logic [DataW-1:0] val,
                                         logic acc, logic [DataW-1:0] front,
                                         logic [DataW-1:0] rear, logic empty, logic full);
    plan_row_t r;
    r = op_row(op, val);
    r.has_want = 1'b1;
    r.want = '{accepted: acc, front: front, rear: rear, empty: empty, full: full};
    return r;
  endfunction

  function automatic void check_field(string name, logic [DataW-1:0] want,
                                      logic [DataW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic drop_valid();
    if (offering) begin
      in_valid_i <= 1'b0;
      offering = 1'b0;
    end
  endtask

  // offer one beat and keep it up until taken; valid stays high afterwards
  task automatic drive_beat(logic [OpW-1:0] op, logic [DataW-1:0] val, logic has_want,
                            deque_view_t want);
    deque_view_t v;
    in_valid_i <= 1'b1;
    op_i       <= op;
    value_i    <= val;
    offering = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    v = predict_step(op, val);
    pending_views = {pending_views, (has_want ? want : v)};
    beats_sent++;
  endtask

  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      drop_valid();
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(0, 24);
    end
  endtask

  task automatic set_capacity(logic [CntW-1:0] cap);
    drop_valid();
    while (pending_views.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= cap;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ring_cap   = cap;
    ring_head  = 0;
    ring_tail  = 0;
    ring_count = 0;
  endtask

  initial begin
    plan_row_t        plan[$];
    int unsigned      bias;
    int unsigned      pick;
    logic [OpW-1:0]   op;
    logic [DataW-1:0] val;

    foreach (ring_slots[i]) ring_slots[i] = '0;
    ring_head  = 0;
    ring_tail  = 0;
    ring_count = 0;
    ring_cap   = CntW'(CapResetV);

    plan = {plan, want_row(OP_DEL_FRONT, 32'h0, 1'b0, EmptyMark, EmptyMark, 1'b1, 1'b0)};
    plan = {plan, want_row(OP_DEL_BACK, 32'h0, 1'b0, EmptyMark, EmptyMark, 1'b1, 1'b0)};
    plan = {plan, want_row(OP_NONE, 32'h1, 1'b0, EmptyMark, EmptyMark, 1'b1, 1'b0)};
    plan = {plan, want_row(3'd7, 32'h2, 1'b0, EmptyMark, EmptyMark, 1'b1, 1'b0)};
    plan = {plan, op_row(3'd5, 32'hFFFF_FFFF)};
    plan = {plan, op_row(3'd6, 32'h0)};
    plan = {plan, want_row(OP_INS_BACK, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           1'b0, 1'b0)};
    plan = {plan, want_row(OP_INS_FRONT, 32'h8000_0000, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF,
                           1'b0, 1'b0)};
    plan = {plan, op_row(OP_INS_BACK, 32'h0)};
    plan = {plan, op_row(OP_INS_FRONT, 32'hFFFF_FFFF)};
    plan = {plan, op_row(3'd5, 32'h1234)};
    plan = {plan, op_row(OP_DEL_BACK, 32'h0)};
    plan = {plan, op_row(OP_DEL_FRONT, 32'h0)};
    // capacity 0 behaves as 1
    plan = {plan, cfg_row(5'd0)};
    plan = {plan, want_row(OP_INS_FRONT, 32'h1234_5678, 1'b1, 32'h1234_5678, 32'h1234_5678,
                           1'b0, 1'b1)};
    plan = {plan, want_row(OP_INS_BACK, 32'h5555_AAAA, 1'b0, 32'h1234_5678, 32'h1234_5678,
                           1'b0, 1'b1)};
    plan = {plan, want_row(OP_DEL_BACK, 32'h0, 1'b1, EmptyMark, EmptyMark, 1'b1, 1'b0)};
    plan = {plan, cfg_row(5'd2)};
    plan = {plan, op_row(OP_INS_FRONT, 32'hA5A5_A5A5)};
    plan = {plan, op_row(OP_INS_FRONT, 32'h5A5A_5A5A)};
    plan = {plan, op_row(OP_INS_BACK, 32'h1)};
    plan = {plan, op_row(OP_DEL_FRONT, 32'h0)};
    plan = {plan, op_row(OP_INS_BACK, 32'h2)};
    plan = {plan, op_row(OP_DEL_BACK, 32'h0)};
    plan = {plan, op_row(OP_DEL_BACK, 32'h0)};
    plan = {plan, op_row(OP_DEL_FRONT, 32'h0)};
    // above depth behaves as depth
    plan = {plan, cfg_row(5'd31)};
    plan = {plan, op_row(OP_INS_FRONT, 32'hDEAD_BEEF)};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        set_capacity(plan[i].cap);
      end else begin
        drive_beat(plan[i].op, plan[i].value, plan[i].has_want, plan[i].want);
        pace_sender();
      end
    end

    bias = 50;
    for (int phase = 0; phase < NumPhases; phase++) begin
      set_capacity((phase == 4) ? CntW'($urandom_range(0, 31)) : PhaseCaps[phase]);
      for (int n = 0; n < PhaseBeats; n++) begin
        if (n % 20 == 0) begin
          case ($urandom_range(0, 2))
            0: bias = 85;
            1: bias = 50;
            default: bias = 15;
          endcase
        end
        pick = $urandom_range(0, 99);
        if (pick < 4) op = OpW'($urandom_range(OP_NONE, 7));
        else if ($urandom_range(0, 99) < bias) op = $urandom_range(0, 1) ? OP_INS_FRONT
                                                                          : OP_INS_BACK;
        else op = $urandom_range(0, 1) ? OP_DEL_FRONT : OP_DEL_BACK;
        case ($urandom_range(0, 9))
          0: val = 32'h8000_0000;
          1: val = 32'h7FFF_FFFF;
          2: val = '1;
          3: val = '0;
          default: val = $urandom;
        endcase
        drive_beat(op, val, 1'b0, '0);
        pace_sender();
      end
    end

    drop_valid();
    while (pending_views.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // result side: check, then pick next ready
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned hold_left;
    bit          held;
    deque_view_t want;
    deque_view_t got;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        got = {accepted_o, front_value_o, rear_value_o, is_empty_o, is_full_o};
        if (pending_views.size() == 0) begin
          $error("result beat with no expectation pending");
          fail_count++;
        end else begin
          want = pending_views[0];
          pending_views.delete(0);
          check_field("accepted", DataW'(want.accepted), DataW'(got.accepted));
          check_field("front_value", want.front, got.front);
          check_field("rear_value", want.rear, got.rear);
          check_field("is_empty", DataW'(want.empty), DataW'(got.empty));
          check_field("is_full", DataW'(want.full), DataW'(got.full));
        end
      end
      // one long back-pressure window while input keeps coming
      if (!held && beats_sent >= 400) begin
        held = 1'b1;
        hold_left = 150;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 80);
      end
      mode_left--;
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
        quiet = 0;
      else
        quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

endmodule
